>>> rtl/bcdl_pkg.sv
// ----------------------------------------------------------------------------
// bcdl_pkg: shared types and constants for the current derating limiter
// Operation codes, register indexes, item and divider structs, sequencer
// states.
// ----------------------------------------------------------------------------
package bcdl_pkg;

   localparam int ReqDataW  = 96;   // 92 bits of fields, padded to bytes
   localparam int RspDataW  = 72;   // 66 bits of fields, padded to bytes
   localparam int OpW       = 2;
   localparam int RspUserW  = 2;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 16;
   localparam int CurW      = 17;   // current fields, signed
   localparam int ByteW     = 8;    // ids, temperatures, charge levels
   localparam int AgeW      = 16;
   localparam int ProdW     = CurW + ByteW;
   localparam int QuoW      = CurW;
   localparam int CurrentWidthDef = 18;

   typedef enum logic [OpW-1:0] {
      OP_STATUS = 2'd0,
      OP_QUERY  = 2'd1,
      OP_TICK   = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [CsrIndexW-1:0] {
      REG_ENABLE     = 3'd0,
      REG_TEMP_START = 3'd1,
      REG_TEMP_END   = 3'd2,
      REG_SOC_START  = 3'd3,
      REG_SOC_END    = 3'd4,
      REG_AGE_LIMIT  = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_STATUS,
      KIND_QUERY,
      KIND_TICK
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [ByteW-1:0]        monitor_id;
      logic signed [ByteW-1:0] cell_temp;
      logic [ByteW-1:0]        charge_level;
      logic signed [CurW-1:0]  conf_min;
      logic signed [CurW-1:0]  conf_max;
      logic signed [CurW-1:0]  pres_min;
      logic signed [CurW-1:0]  pres_max;
   } item_type;

   typedef struct packed {
      logic             start;
      logic [ProdW-1:0] dividend;
      logic [ByteW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [QuoW-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                    enable;
      logic signed [ByteW-1:0] temp_start;
      logic signed [ByteW-1:0] temp_end;
      logic [ByteW-1:0]        soc_start;
      logic [ByteW-1:0]        soc_end;
      logic [AgeW-1:0]         age_limit;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TEMP_MUL,
      ST_TEMP_START,
      ST_TEMP_WAIT,
      ST_TEMP_APPLY,
      ST_SOC_MUL,
      ST_SOC_START,
      ST_SOC_WAIT,
      ST_SOC_APPLY,
      ST_RESULT
   } back_state_type;

endpackage

>>> rtl/bcdl_front.sv
// ----------------------------------------------------------------------------
// bcdl_front: input classifier and item queue
// Decodes the operation of each request, drops unused codes and holds up
// to two classified items for the back end.
// ----------------------------------------------------------------------------
module bcdl_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bcdl_pkg::ReqDataW-1:0] req_tdata,
   input  logic [bcdl_pkg::OpW-1:0]      req_tuser,
   output logic                          item_valid,
   input  logic                          item_ready,
   output bcdl_pkg::item_type            item
);
   import bcdl_pkg::*;

   localparam int Depth = 2;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   item_type        q_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   item_type        decoded;
   logic            known_op;
   logic            push;
   logic            pop;

   always_comb begin
      decoded.kind         = KIND_STATUS;
      decoded.monitor_id   = req_tdata[7:0];
      decoded.cell_temp    = req_tdata[15:8];
      decoded.charge_level = req_tdata[23:16];
      decoded.conf_min     = req_tdata[40:24];
      decoded.conf_max     = req_tdata[57:41];
      decoded.pres_min     = req_tdata[74:58];
      decoded.pres_max     = req_tdata[91:75];
      known_op             = 1'b1;
      unique case (op_type'(req_tuser))
         OP_STATUS: decoded.kind = KIND_STATUS;
         OP_QUERY:  decoded.kind = KIND_QUERY;
         OP_TICK:   decoded.kind = KIND_TICK;
         default:   known_op = 1'b0;
      endcase
   end

   assign req_tready = (count_ff != CntW'(Depth));
   assign item_valid = (count_ff != '0);
   assign item       = q_ff[rd_ptr_ff];

   // drop unused codes at the door: accepted but never queued
   assign push = req_tvalid && req_tready && known_op;
   assign pop  = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

>>> rtl/bcdl_div.sv
// ----------------------------------------------------------------------------
// bcdl_div: serial restoring divider
// One quotient bit per cycle. The caller guarantees the quotient fits in
// QuoW bits, so the upper dividend bits seed the remainder.
// ----------------------------------------------------------------------------
module bcdl_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bcdl_pkg::div_req_type div_req,
   output bcdl_pkg::div_rsp_type div_rsp
);
   import bcdl_pkg::*;

   localparam int CntW = $clog2(QuoW + 1);

   logic [ByteW-1:0] rem_ff, rem_in;
   logic [QuoW-1:0]  quo_ff, quo_in;
   logic [ByteW-1:0] den_ff, den_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [ByteW:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[QuoW-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend[ProdW-1:QuoW];
         quo_in  = div_req.dividend[QuoW-1:0];
         den_in  = div_req.divisor;
         cnt_in  = CntW'(QuoW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? ByteW'(trial - {1'b0, den_ff}) : trial[ByteW-1:0];
         quo_in = {quo_ff[QuoW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> rtl/bcdl_back.sv
// ----------------------------------------------------------------------------
// bcdl_back: record keeping and limit sequencer
// Holds the control registers and the hottest/lowest records, applies
// status and tick items as the idle state takes them, and walks a query
// through the temperature and charge tapers on the shared divider.
// ----------------------------------------------------------------------------
module bcdl_back #(
   parameter int CURRENT_WIDTH = bcdl_pkg::CurrentWidthDef
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bcdl_pkg::CsrIndexW-1:0] csr_index,
   input  logic [bcdl_pkg::CsrDataW-1:0]  csr_wdata,
   input  logic                           item_valid,
   output logic                           item_ready,
   input  bcdl_pkg::item_type             item,
   output bcdl_pkg::div_req_type          div_req,
   input  bcdl_pkg::div_rsp_type          div_rsp,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bcdl_pkg::RspDataW-1:0]  rsp_tdata,
   output logic [bcdl_pkg::RspUserW-1:0]  rsp_tuser
);
   import bcdl_pkg::*;

   // largest derated magnitude the internal path carries
   localparam logic [CurW-1:0] MagCap = (CURRENT_WIDTH >= CurW) ? {CurW{1'b1}} :
                                        CurW'((64'd1 << CURRENT_WIDTH) - 64'd1);
   localparam int PadW = RspDataW - 2 * CurW - 4 * ByteW;

   function automatic logic [CurW-1:0] mag(input logic signed [CurW-1:0] v);
      mag = v[CurW-1] ? CurW'(-v) : CurW'(v);
   endfunction

   function automatic logic [CurW-1:0] cap(input logic [CurW-1:0] v);
      cap = (v > MagCap) ? MagCap : v;
   endfunction

   back_state_type state_ff, state_in;
   cfg_type        cfg_ff, cfg_in;

   logic                    temp_valid_ff, temp_valid_in;
   logic [ByteW-1:0]        temp_id_ff, temp_id_in;
   logic signed [ByteW-1:0] temp_value_ff, temp_value_in;
   logic [AgeW-1:0]         temp_age_ff, temp_age_in;
   logic                    soc_valid_ff, soc_valid_in;
   logic [ByteW-1:0]        soc_id_ff, soc_id_in;
   logic [ByteW-1:0]        soc_value_ff, soc_value_in;
   logic [AgeW-1:0]         soc_age_ff, soc_age_in;

   item_type               cur_ff, cur_in;
   logic signed [CurW-1:0] bmin_ff, bmin_in;
   logic signed [CurW-1:0] bmax_ff, bmax_in;
   logic [ProdW-1:0]       prod_ff, prod_in;
   logic [ByteW-1:0]       den_ff, den_in;
   logic                   below_ff, below_in;
   logic                   above_ff, above_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0]    rsp_data_ff, rsp_data_in;
   logic [RspUserW-1:0]    rsp_user_ff, rsp_user_in;

   logic pop;
   logic rsp_load;

   logic                   temp_fresh;
   logic                   soc_fresh;
   logic signed [ByteW:0]  te_t;
   logic signed [ByteW:0]  te_ts;
   logic [ByteW-1:0]       s_se;
   logic [ByteW-1:0]       ss_se;
   logic [CurW-1:0]        mc;
   logic [CurW-1:0]        lim;
   logic signed [CurW-1:0] lmin;
   logic signed [CurW-1:0] lmax;

   assign csr_ready = 1'b1;

   // ---------------- control registers ----------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_ENABLE:     cfg_in.enable     = csr_wdata[0];
            REG_TEMP_START: cfg_in.temp_start = csr_wdata[ByteW-1:0];
            REG_TEMP_END:   cfg_in.temp_end   = csr_wdata[ByteW-1:0];
            REG_SOC_START:  cfg_in.soc_start  = csr_wdata[ByteW-1:0];
            REG_SOC_END:    cfg_in.soc_end    = csr_wdata[ByteW-1:0];
            REG_AGE_LIMIT:  cfg_in.age_limit  = csr_wdata[AgeW-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (item_valid && item.kind == KIND_QUERY) state_in = ST_TEMP_MUL;
         ST_TEMP_MUL:   state_in = ST_TEMP_START;
         ST_TEMP_START: state_in = ST_TEMP_WAIT;
         ST_TEMP_WAIT:  if (div_rsp.done) state_in = ST_TEMP_APPLY;
         ST_TEMP_APPLY: state_in = ST_SOC_MUL;
         ST_SOC_MUL:    state_in = ST_SOC_START;
         ST_SOC_START:  state_in = ST_SOC_WAIT;
         ST_SOC_WAIT:   if (div_rsp.done) state_in = ST_SOC_APPLY;
         ST_SOC_APPLY:  state_in = ST_RESULT;
         ST_RESULT:     if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_ready       = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor  = den_ff;
      rsp_load         = 1'b0;
      unique case (state_ff)
         ST_IDLE:       item_ready = 1'b1;
         ST_TEMP_START: div_req.start = 1'b1;
         ST_SOC_START:  div_req.start = 1'b1;
         ST_RESULT:     rsp_load = !rsp_valid_ff || rsp_tready;
         default:       item_ready = 1'b0;
      endcase
   end

   assign pop = item_valid && item_ready;

   // ---------------- datapath ----------------
   assign temp_fresh = temp_valid_ff && (temp_age_ff < cfg_ff.age_limit);
   assign soc_fresh  = soc_valid_ff && (soc_age_ff < cfg_ff.age_limit);

   assign te_t  = {cfg_ff.temp_end[ByteW-1], cfg_ff.temp_end} -
                  {temp_value_ff[ByteW-1], temp_value_ff};
   assign te_ts = {cfg_ff.temp_end[ByteW-1], cfg_ff.temp_end} -
                  {cfg_ff.temp_start[ByteW-1], cfg_ff.temp_start};
   assign s_se  = soc_value_ff - cfg_ff.soc_end;
   assign ss_se = cfg_ff.soc_start - cfg_ff.soc_end;

   assign mc  = (mag(cur_ff.conf_min) > mag(cur_ff.conf_max)) ?
                mag(cur_ff.conf_min) : mag(cur_ff.conf_max);
   assign lim = cap(div_rsp.quotient);

   assign lmin = (mag(bmin_ff) < mag(cur_ff.pres_min)) ? bmin_ff : cur_ff.pres_min;
   assign lmax = (mag(bmax_ff) < mag(cur_ff.pres_max)) ? bmax_ff : cur_ff.pres_max;

   always_comb begin
      temp_valid_in = temp_valid_ff;
      temp_id_in    = temp_id_ff;
      temp_value_in = temp_value_ff;
      temp_age_in   = temp_age_ff;
      soc_valid_in  = soc_valid_ff;
      soc_id_in     = soc_id_ff;
      soc_value_in  = soc_value_ff;
      soc_age_in    = soc_age_ff;
      cur_in        = cur_ff;
      bmin_in       = bmin_ff;
      bmax_in       = bmax_ff;
      prod_in       = prod_ff;
      den_in        = den_ff;
      below_in      = below_ff;
      above_in      = above_ff;

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cur_in  = item;
               bmin_in = item.conf_min;
               bmax_in = item.conf_max;
               if (item.kind == KIND_STATUS && cfg_ff.enable) begin
                  if (!temp_valid_ff || temp_age_ff > cfg_ff.age_limit ||
                      temp_value_ff < item.cell_temp || temp_id_ff == item.monitor_id) begin
                     temp_valid_in = 1'b1;
                     temp_id_in    = item.monitor_id;
                     temp_value_in = item.cell_temp;
                     temp_age_in   = '0;
                  end
                  if (!soc_valid_ff || soc_age_ff > cfg_ff.age_limit ||
                      soc_value_ff > item.charge_level || soc_id_ff == item.monitor_id) begin
                     soc_valid_in = 1'b1;
                     soc_id_in    = item.monitor_id;
                     soc_value_in = item.charge_level;
                     soc_age_in   = '0;
                  end
               end
               if (item.kind == KIND_TICK) begin
                  // age both records, hold at full scale
                  if (temp_age_ff != '1) temp_age_in = temp_age_ff + 1'b1;
                  if (soc_age_ff != '1) soc_age_in = soc_age_ff + 1'b1;
               end
            end
         end
         ST_TEMP_MUL: begin
            // thresholds equal and value on them: scale by one
            if (cfg_ff.temp_end == cfg_ff.temp_start) begin
               prod_in = ProdW'(mc);
               den_in  = ByteW'(1);
            end else begin
               prod_in = ProdW'(mc) * ProdW'(te_t[ByteW-1:0]);
               den_in  = te_ts[ByteW-1:0];
            end
            below_in = temp_value_ff < cfg_ff.temp_start;
            above_in = temp_value_ff > cfg_ff.temp_end;
         end
         ST_TEMP_APPLY: begin
            if (cfg_ff.enable && temp_fresh && !below_ff) begin
               if (above_ff) begin
                  bmin_in = '0;
                  bmax_in = '0;
               end else begin
                  if (mag(bmin_ff) > lim) bmin_in = bmin_ff[CurW-1] ? CurW'(-lim) : lim;
                  if (mag(bmax_ff) > lim) bmax_in = bmax_ff[CurW-1] ? CurW'(-lim) : lim;
               end
            end
         end
         ST_SOC_MUL: begin
            if (cfg_ff.soc_start == cfg_ff.soc_end) begin
               prod_in = ProdW'(mag(cur_ff.conf_max));
               den_in  = ByteW'(1);
            end else begin
               prod_in = ProdW'(mag(cur_ff.conf_max)) * ProdW'(s_se);
               den_in  = ss_se;
            end
            below_in = soc_value_ff < cfg_ff.soc_end;
            above_in = soc_value_ff > cfg_ff.soc_start;
         end
         ST_SOC_APPLY: begin
            if (cfg_ff.enable && soc_fresh && !above_ff) begin
               if (below_ff) begin
                  bmax_in = '0;
               end else begin
                  bmax_in = cur_ff.conf_max[CurW-1] ? CurW'(-lim) : lim;
               end
            end
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{PadW{1'b0}}, soc_id_ff, soc_value_ff, temp_id_ff,
                         temp_value_ff, lmax, lmin};
         rsp_user_in  = {soc_fresh, temp_fresh};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         cfg_ff.enable     <= 1'b0;
         cfg_ff.temp_start <= 8'sd45;
         cfg_ff.temp_end   <= 8'sd65;
         cfg_ff.soc_start  <= 8'd13;
         cfg_ff.soc_end    <= 8'd0;
         cfg_ff.age_limit  <= 16'd2000;
         temp_valid_ff     <= 1'b0;
         temp_id_ff        <= '0;
         temp_value_ff     <= '0;
         temp_age_ff       <= '0;
         soc_valid_ff      <= 1'b0;
         soc_id_ff         <= '0;
         soc_value_ff      <= '0;
         soc_age_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_ff        <= cfg_in;
         temp_valid_ff <= temp_valid_in;
         temp_id_ff    <= temp_id_in;
         temp_value_ff <= temp_value_in;
         temp_age_ff   <= temp_age_in;
         soc_valid_ff  <= soc_valid_in;
         soc_id_ff     <= soc_id_in;
         soc_value_ff  <= soc_value_in;
         soc_age_ff    <= soc_age_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      bmin_ff     <= bmin_in;
      bmax_ff     <= bmax_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      below_ff    <= below_in;
      above_ff    <= above_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> rtl/bms_current_derating_limiter.sv
// ----------------------------------------------------------------------------
// bms_current_derating_limiter: battery current derating by temperature/SOC
// Tracks the hottest and lowest-charge monitor records and derates the
// regen and drive current limits on request.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per transfer; tuser carries the operation (status
//            report, limit query, tick). Unused operation codes are taken
//            and dropped.
//   rsp_*  : one result per limit query, none for reports and ticks.
//   csr_*  : register writes, always ready; write only while no item is
//            in flight.
//   A two-entry queue sits between the input classifier and the sequencer,
//   so requests are taken while a query is being worked on.
//   Reports and ticks are applied in the sequencer's idle state. A query
//   makes two passes of the one serial divider (17 steps each; the
//   temperature taper, then the charge taper), each with a multiply,
//   start, wait and apply state; the idle state takes the item first and
//   the result state loads the output register last. The sequencer takes
//   the next item only once that result has been loaded.
//   Reset clears both records, loads the register defaults and empties the
//   queue and the output register. When the receiver stalls, the result is
//   held in the output register; the sequencer then waits before loading
//   the next one, and the queue fills and drops req_tready.
// ----------------------------------------------------------------------------
module bms_current_derating_limiter #(
   parameter int CURRENT_WIDTH = bcdl_pkg::CurrentWidthDef
) (
   input  logic                           clock,
   input  logic                           reset,
   // tdata: monitor_id, cell_temp, charge_level, conf_min_current,
   //        conf_max_current, present_min_current, present_max_current, pad
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bcdl_pkg::ReqDataW-1:0]  req_tdata,
   // tuser: operation
   input  logic [bcdl_pkg::OpW-1:0]       req_tuser,
   // tdata: limited_min_current, limited_max_current, hottest_temp,
   //        hottest_id, lowest_charge, lowest_id, pad
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bcdl_pkg::RspDataW-1:0]  rsp_tdata,
   // tuser: temp_fresh, charge_fresh
   output logic [bcdl_pkg::RspUserW-1:0]  rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bcdl_pkg::CsrIndexW-1:0] csr_index,
   input  logic [bcdl_pkg::CsrDataW-1:0]  csr_wdata
);
   import bcdl_pkg::*;

   item_type    item;
   logic        item_valid;
   logic        item_ready;
   div_req_type div_req;
   div_rsp_type div_rsp;

   bcdl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   bcdl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   bcdl_back #(
      .CURRENT_WIDTH (CURRENT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> rtl/bcdl_checker.sv
// ----------------------------------------------------------------------------
// bcdl_checker: port-level checks for the current derating limiter
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module bcdl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [bcdl_pkg::RspDataW-1:0] rsp_tdata,
   input logic [bcdl_pkg::RspUserW-1:0] rsp_tuser
);

   // a stalled result holds until transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   // a query walks the whole sequencer first: no result right out of reset
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3))
      else $error("result too soon after reset");

endmodule

bind bms_current_derating_limiter bcdl_checker u_checker (.*);

>>> tb/bms_current_derating_limiter_tb.sv
// ----------------------------------------------------------------------------
// bms_current_derating_limiter_tb: self-checking bench for the derating limiter
// Streams status reports, ticks and limit queries into the block, mirrors the
// hottest/lowest-charge records and the taper arithmetic in a local predictor,
// and compares every returned limit transfer field by field. Directed checks
// come first, then randomized phases under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bms_current_derating_limiter_tb;
   import bcdl_pkg::*;

   localparam int CurrentWidth = CurrentWidthDef;
   localparam longint CurMagMax = (longint'(1) << CurrentWidth) - 1;
   localparam int CycleLimit = 2_000_000;
   localparam int DrainCycles = 100;
   localparam int PhaseItems = 230;

   typedef struct packed {
      op_type             op;
      logic [7:0]         monitor_id;
      logic signed [7:0]  cell_temp;
      logic [7:0]         charge_level;
      logic signed [16:0] conf_min;
      logic signed [16:0] conf_max;
      logic signed [16:0] pres_min;
      logic signed [16:0] pres_max;
   } monitor_item_type;

   typedef struct packed {
      logic signed [16:0] lim_min;
      logic signed [16:0] lim_max;
      logic signed [7:0]  hot_temp;
      logic [7:0]         hot_id;
      logic [7:0]         low_charge;
      logic [7:0]         low_id;
      logic               temp_fresh;
      logic               charge_fresh;
   } limits_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ReqDataW-1:0]  req_tdata = '0;
   logic [OpW-1:0]       req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RspDataW-1:0]  rsp_tdata;
   logic [RspUserW-1:0]  rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [CsrDataW-1:0]  csr_wdata = '0;

   // mirrored block state
   cfg_type           limiter_cfg;
   logic              hot_valid = 1'b0;
   logic [7:0]        hot_id = '0;
   logic signed [7:0] hot_value = '0;
   logic [15:0]       hot_age = '0;
   logic              low_valid = 1'b0;
   logic [7:0]        low_id = '0;
   logic [7:0]        low_value = '0;
   logic [15:0]       low_age = '0;

   limits_type  expected_limits[$];
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   bit          idle_on = 1'b0;
   int unsigned idle_pct = 0;
   int unsigned stall_left = 0;

   bms_current_derating_limiter #(
      .CURRENT_WIDTH(CurrentWidth)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver stalls in bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < idle_pct) begin
         stall_left <= $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic limits_type derate_limits(monitor_item_type it);
      longint     cmin, cmax, pmin, pmax, bmin, bmax, mc, t, ts, te, s, ss, se;
      logic       tf, cf;
      limits_type r;
      cmin = $signed(it.conf_min);
      cmax = $signed(it.conf_max);
      pmin = $signed(it.pres_min);
      pmax = $signed(it.pres_max);
      bmin = cmin;
      bmax = cmax;
      tf = hot_valid && (hot_age < limiter_cfg.age_limit);
      cf = low_valid && (low_age < limiter_cfg.age_limit);
      if (limiter_cfg.enable && tf) begin
         t  = $signed(hot_value);
         ts = $signed(limiter_cfg.temp_start);
         te = $signed(limiter_cfg.temp_end);
         if (t >= ts && t > te) begin
            bmin = 0;
            bmax = 0;
         end else if (t >= ts) begin
            // scale the larger configured magnitude, clamp both limits to it
            mc = (magnitude(cmax) > magnitude(cmin)) ? magnitude(cmax) : magnitude(cmin);
            if (te != ts) mc = (mc * (te - t)) / (te - ts);
            if (mc > CurMagMax) mc = CurMagMax;
            if (magnitude(bmin) > mc) bmin = (bmin < 0) ? -mc : mc;
            if (magnitude(bmax) > mc) bmax = (bmax < 0) ? -mc : mc;
         end
      end
      if (limiter_cfg.enable && cf) begin
         s  = longint'(low_value);
         ss = longint'(limiter_cfg.soc_start);
         se = longint'(limiter_cfg.soc_end);
         if (s <= ss && s < se) begin
            bmax = 0;
         end else if (s <= ss) begin
            // charge taper replaces the drive limit outright
            mc = magnitude(cmax);
            if (ss != se) mc = (mc * (s - se)) / (ss - se);
            if (mc > CurMagMax) mc = CurMagMax;
            bmax = (cmax < 0) ? -mc : mc;
         end
      end
      if (magnitude(bmin) < magnitude(pmin)) pmin = bmin;
      if (magnitude(bmax) < magnitude(pmax)) pmax = bmax;
      r.lim_min      = pmin[16:0];
      r.lim_max      = pmax[16:0];
      r.hot_temp     = hot_value;
      r.hot_id       = hot_id;
      r.low_charge   = low_value;
      r.low_id       = low_id;
      r.temp_fresh   = tf;
      r.charge_fresh = cf;
      return r;
   endfunction

   function automatic void apply_item(monitor_item_type it);
      case (it.op)
         OP_STATUS: begin
            if (limiter_cfg.enable) begin
               if (!hot_valid || hot_age > limiter_cfg.age_limit ||
                   $signed(hot_value) < $signed(it.cell_temp) || hot_id == it.monitor_id) begin
                  hot_valid = 1'b1;
                  hot_id    = it.monitor_id;
                  hot_value = it.cell_temp;
                  hot_age   = '0;
               end
               if (!low_valid || low_age > limiter_cfg.age_limit ||
                   low_value > it.charge_level || low_id == it.monitor_id) begin
                  low_valid = 1'b1;
                  low_id    = it.monitor_id;
                  low_value = it.charge_level;
                  low_age   = '0;
               end
            end
         end
         OP_TICK: begin
            if (hot_age != 16'hFFFF) hot_age = hot_age + 1'b1;
            if (low_age != 16'hFFFF) low_age = low_age + 1'b1;
         end
         OP_QUERY: expected_limits.push_back(derate_limits(it));
         default: ;
      endcase
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      limits_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.lim_min      = rsp_tdata[16:0];
         got.lim_max      = rsp_tdata[33:17];
         got.hot_temp     = rsp_tdata[41:34];
         got.hot_id       = rsp_tdata[49:42];
         got.low_charge   = rsp_tdata[57:50];
         got.low_id       = rsp_tdata[65:58];
         got.temp_fresh   = rsp_tuser[0];
         got.charge_fresh = rsp_tuser[1];
         if (expected_limits.size() == 0) begin
            mismatches++;
            $display("%0t unexpected transfer: expected none, actual min %0d max %0d",
                     $time, got.lim_min, got.lim_max);
         end else begin
            want = expected_limits.pop_front();
            check_field("limited_min_current", $signed(want.lim_min), $signed(got.lim_min));
            check_field("limited_max_current", $signed(want.lim_max), $signed(got.lim_max));
            check_field("hottest_temp", $signed(want.hot_temp), $signed(got.hot_temp));
            check_field("hottest_id", want.hot_id, got.hot_id);
            check_field("lowest_charge", want.low_charge, got.low_charge);
            check_field("lowest_id", want.low_id, got.low_id);
            check_field("temp_fresh", want.temp_fresh, got.temp_fresh);
            check_field("charge_fresh", want.charge_fresh, got.charge_fresh);
         end
      end
   end

   function automatic logic signed [16:0] rand_current();
      case ($urandom_range(0, 5))
         0: return -17'sd50000;
         1: return 17'sd50000;
         2: return '0;
         3: return 17'(int'($urandom_range(0, 2000)) - 1000);
         default: return 17'(int'($urandom_range(0, 100000)) - 50000);
      endcase
   endfunction

   function automatic monitor_item_type rand_item(op_type op);
      monitor_item_type it;
      it.op           = op;
      it.monitor_id   = 8'($urandom);
      it.cell_temp    = 8'($urandom);
      it.charge_level = 8'($urandom);
      it.conf_min     = rand_current();
      it.conf_max     = rand_current();
      it.pres_min     = rand_current();
      it.pres_max     = rand_current();
      return it;
   endfunction

   // value near the two thresholds, sometimes anywhere in range
   function automatic int pick_near(int a, int b, int floor_v, int ceil_v);
      int lo, hi;
      lo = ((a < b) ? a : b) - 4;
      hi = ((a > b) ? a : b) + 4;
      if (lo < floor_v) lo = floor_v;
      if (hi > ceil_v) hi = ceil_v;
      if ($urandom_range(0, 3) == 0) begin
         lo = floor_v;
         hi = ceil_v;
      end
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   task automatic send_item(monitor_item_type it);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {4'd0, it.pres_max, it.pres_min, it.conf_max, it.conf_min,
                     it.charge_level, it.cell_temp, it.monitor_id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_item(it);
      if (idle_on && $urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end
   endtask

   task automatic send_report(int id, int temp, int level);
      monitor_item_type it;
      it = rand_item(OP_STATUS);
      it.monitor_id   = 8'(id);
      it.cell_temp    = 8'(temp);
      it.charge_level = 8'(level);
      send_item(it);
   endtask

   task automatic send_query(int cmin, int cmax, int pmin, int pmax);
      monitor_item_type it;
      it = rand_item(OP_QUERY);
      it.conf_min = 17'(cmin);
      it.conf_max = 17'(cmax);
      it.pres_min = 17'(pmin);
      it.pres_max = 17'(pmax);
      send_item(it);
   endtask

   // hold until every query has answered and trailing reports have retired
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_limits.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ENABLE:     limiter_cfg.enable     = value[0];
         REG_TEMP_START: limiter_cfg.temp_start = value[7:0];
         REG_TEMP_END:   limiter_cfg.temp_end   = value[7:0];
         REG_SOC_START:  limiter_cfg.soc_start  = value[7:0];
         REG_SOC_END:    limiter_cfg.soc_end    = value[7:0];
         REG_AGE_LIMIT:  limiter_cfg.age_limit  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_config(cfg_type c);
      write_reg(REG_ENABLE, {15'd0, c.enable});
      write_reg(REG_TEMP_START, {8'd0, c.temp_start});
      write_reg(REG_TEMP_END, {8'd0, c.temp_end});
      write_reg(REG_SOC_START, {8'd0, c.soc_start});
      write_reg(REG_SOC_END, {8'd0, c.soc_end});
      write_reg(REG_AGE_LIMIT, c.age_limit);
   endtask

   function automatic cfg_type draw_config(int phase);
      cfg_type c;
      c.enable     = ($urandom_range(0, 5) != 0);
      c.temp_start = 8'($urandom);
      c.temp_end   = c.temp_start + 8'($urandom_range(0, 40));
      c.soc_end    = 8'($urandom);
      c.soc_start  = c.soc_end + 8'($urandom_range(0, 60));
      c.age_limit  = 16'($urandom_range(1, 40));
      case (phase)
         0: begin
            c.enable     = 1'b1;
            c.temp_start = -8'sd128;
            c.temp_end   = 8'sd127;
            c.soc_start  = 8'd255;
            c.soc_end    = 8'd0;
            c.age_limit  = 16'd1;
         end
         1: begin
            c.enable     = 1'b1;
            c.temp_start = 8'sd127;
            c.temp_end   = -8'sd128;
            c.soc_start  = 8'd0;
            c.soc_end    = 8'd255;
            c.age_limit  = 16'hFFFF;
         end
         2: c.enable = 1'b0;
         3: begin
            c.enable     = 1'b1;
            c.temp_start = 8'sd40;
            c.temp_end   = 8'sd70;
            c.soc_start  = 8'd60;
            c.soc_end    = 8'd10;
         end
         default: ;
      endcase
      return c;
   endfunction

   // reset defaults: reports dropped, limits pass through the caller's check
   task automatic test_disabled();
      send_report(7, 100, 20);
      send_item(rand_item(OP_UNUSED));
      send_item(rand_item(OP_TICK));
      send_query(-50000, 50000, -20000, 30000);
      send_query(-1000, 2000, -50000, 50000);
   endtask

   task automatic test_temperature_taper();
      drain();
      write_reg(REG_ENABLE, 16'd1);
      send_report(1, 30, 200);
      send_query(-50000, 50000, -50000, 50000);
      send_report(1, 55, 200);
      send_query(-30000, 40000, -50000, 50000);
      send_report(2, 127, 200);
      send_query(-50000, 50000, -50000, 50000);
      send_report(3, -128, 0);
      send_query(-50000, 50000, -50000, 50000);
      send_report(3, -128, 7);
      send_query(20000, -40000, 50000, -50000);
   endtask

   task automatic test_equal_thresholds();
      drain();
      write_reg(REG_TEMP_START, 16'd60);
      write_reg(REG_TEMP_END, 16'd60);
      write_reg(REG_SOC_START, 16'd100);
      write_reg(REG_SOC_END, 16'd100);
      send_report(2, 60, 100);
      send_report(3, 60, 100);
      send_query(-50000, 50000, -50000, 50000);
   endtask

   // age at the limit is neither fresh nor stale; one more tick makes it stale
   task automatic test_staleness();
      drain();
      write_reg(REG_TEMP_START, 16'd45);
      write_reg(REG_TEMP_END, 16'd65);
      write_reg(REG_AGE_LIMIT, 16'd2);
      send_item(rand_item(OP_TICK));
      send_item(rand_item(OP_TICK));
      send_report(9, -100, 255);
      send_query(-50000, 50000, -50000, 50000);
      send_item(rand_item(OP_TICK));
      send_report(9, -100, 255);
      send_query(-50000, 50000, -50000, 50000);
   endtask

   // full-scale age limit keeps records fresh across many ticks
   task automatic test_wide_age_limit();
      drain();
      write_reg(REG_AGE_LIMIT, 16'hFFFF);
      idle_on = 1'b0;
      send_report(9, 10, 50);
      repeat (20) send_item(rand_item(OP_TICK));
      send_query(-50000, 50000, -50000, 50000);
      send_report(30, -128, 255);
      send_query(-50000, 50000, -50000, 50000);
   endtask

   task automatic test_random_phases();
      cfg_type c;
      int      roll;
      for (int p = 0; p < 8; p++) begin
         drain();
         c = draw_config(p);
         load_config(c);
         for (int n = 0; n < PhaseItems; n++) begin
            if (n % 60 == 0) begin
               idle_on  = (p != 7) && ($urandom_range(0, 3) != 0);
               idle_pct = $urandom_range(5, 40);
            end
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
               send_report(($urandom_range(0, 3) != 0) ? $urandom_range(1, 4) :
                                                         $urandom_range(0, 255),
                           pick_near(int'($signed(limiter_cfg.temp_start)),
                                     int'($signed(limiter_cfg.temp_end)), -128, 127),
                           pick_near(int'(limiter_cfg.soc_start), int'(limiter_cfg.soc_end),
                                     0, 255));
            end else if (roll < 60) begin
               send_item(rand_item(OP_TICK));
            end else if (roll < 95) begin
               send_item(rand_item(OP_QUERY));
            end else begin
               send_item(rand_item(OP_UNUSED));
            end
         end
      end
   endtask

   initial begin
      limiter_cfg.enable     = 1'b0;
      limiter_cfg.temp_start = 8'sd45;
      limiter_cfg.temp_end   = 8'sd65;
      limiter_cfg.soc_start  = 8'd13;
      limiter_cfg.soc_end    = 8'd0;
      limiter_cfg.age_limit  = 16'd2000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_on  = 1'b1;
      idle_pct = 30;
      test_disabled();
      test_temperature_taper();
      test_equal_thresholds();
      test_staleness();
      test_wide_age_limit();
      test_random_phases();
      drain();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/bcdl_pkg.sv
rtl/bcdl_front.sv
rtl/bcdl_div.sv
rtl/bcdl_back.sv
rtl/bms_current_derating_limiter.sv
rtl/bcdl_checker.sv
tb/bms_current_derating_limiter_tb.sv
